/* design/abp_pkg.sv */
// Constants, codes and types shared by the alpha blend pixel pipeline.
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned PROD_W   = 2 * CHAN_W;
   localparam int unsigned NUM_CHAN = 3;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // Blend mode codes
   localparam logic [1:0] MODE_SRC_ALPHA = 2'd0;
   localparam logic [1:0] MODE_ADD_GLOBAL = 2'd1;
   localparam logic [1:0] MODE_SUB_GLOBAL = 2'd2;
   localparam logic [1:0] MODE_GLOBAL = 2'd3;

   // Register indexes
   localparam logic REG_BLEND_MODE   = 1'b0;
   localparam logic REG_GLOBAL_ALPHA = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef chan_type [NUM_CHAN-1:0] rgb_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef prod_type [NUM_CHAN-1:0] rgb_prod_type;

   // Select the blend weight for one pixel.
   function automatic chan_type pick_weight(input logic [1:0] mode, input chan_type sa,
                                            input chan_type ga);
      logic [CHAN_W:0] sum;
      chan_type        w;
      sum = {1'b0, sa} + {1'b0, ga};
      unique case (mode)
         MODE_SRC_ALPHA:  w = sa;
         MODE_ADD_GLOBAL: w = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
         MODE_SUB_GLOBAL: w = (sa > ga) ? chan_type'(sa - ga) : '0;
         MODE_GLOBAL:     w = ga;
         default:         w = sa;
      endcase
      return w;
   endfunction

   // Exact floor(x / 255) for x up to 255 * 255.
   function automatic chan_type div255(input logic [PROD_W:0] x);
      logic [PROD_W:0] t;
      t = x + (x >> CHAN_W) + 17'd1;
      return t[PROD_W-1:CHAN_W];
   endfunction

endpackage

`default_nettype wire

/* design/alpha_blend_pixel.sv */
// Top level: three-stage pipelined RGBA blend of a source pixel over a destination pixel.
//
//  channel | direction | handshake          | beat contents
//  req_    | in        | valid / ready      | dst and src RGBA, 8 bits each
//  rsp_    | out       | valid / ready      | blended RGB, dst alpha
//  csr_    | in        | write enable only  | 1-bit index, 8-bit data
//
// Throughput is one beat per cycle while rsp_ready does not stall the pipeline.
// Stage 1 picks the weight, stage 2 holds the six 8x8 products,
// stage 3 adds and divides by 255 into the output register.
// Each stage holds its beat while the next is full and stalled; bubbles close up.
// Synchronous reset empties the pipeline and sets mode 0, global alpha 255.
`timescale 1ns / 1ps
`default_nettype none

module alpha_blend_pixel
   import abp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_dst_red,
   input  wire logic [7:0] req_dst_green,
   input  wire logic [7:0] req_dst_blue,
   input  wire logic [7:0] req_dst_alpha,
   input  wire logic [7:0] req_src_red,
   input  wire logic [7:0] req_src_green,
   input  wire logic [7:0] req_src_blue,
   input  wire logic [7:0] req_src_alpha,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue,
   output logic [7:0]      rsp_out_alpha,

   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [7:0] csr_wdata
);

   logic [1:0] blend_mode_ff;
   chan_type   global_alpha_ff;

   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic         s1_adv, s2_adv, s3_adv;
   logic         s1_open, s2_open, s3_open;

   chan_type     s1_weight_ff, s1_weight_in;
   rgb_type      s1_dst_ff, s1_src_ff;
   chan_type     s1_alpha_ff;

   rgb_prod_type s2_dprod_ff, s2_dprod_in;
   rgb_prod_type s2_sprod_ff, s2_sprod_in;
   chan_type     s2_alpha_ff;

   rgb_type      s3_rgb_ff, s3_rgb_in;
   chan_type     s3_alpha_ff;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff   <= MODE_SRC_ALPHA;
         global_alpha_ff <= CHAN_MAX;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BLEND_MODE:   blend_mode_ff   <= csr_wdata[1:0];
            REG_GLOBAL_ALPHA: global_alpha_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // A stage can take a beat when empty or when its beat moves on this cycle.
   assign s3_open = !s3_valid_ff || rsp_ready;
   assign s2_open = !s2_valid_ff || s3_open;
   assign s1_open = !s1_valid_ff || s2_open;

   assign req_ready = s1_open;
   assign s1_adv    = req_valid && s1_open;
   assign s2_adv    = s1_valid_ff && s2_open;
   assign s3_adv    = s2_valid_ff && s3_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_open) s1_valid_ff <= req_valid;
         if (s2_open) s2_valid_ff <= s1_valid_ff;
         if (s3_open) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: weight select
   assign s1_weight_in = pick_weight(blend_mode_ff, req_src_alpha, global_alpha_ff);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_weight_ff <= s1_weight_in;
         s1_dst_ff    <= {req_dst_blue, req_dst_green, req_dst_red};
         s1_src_ff    <= {req_src_blue, req_src_green, req_src_red};
         s1_alpha_ff  <= req_dst_alpha;
      end
   end

   // Stage 2: one product per operand per channel
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         s2_dprod_in[i] = prod_type'(s1_dst_ff[i]) *
                          prod_type'(chan_type'(CHAN_MAX - s1_weight_ff));
         s2_sprod_in[i] = prod_type'(s1_src_ff[i]) * prod_type'(s1_weight_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s2_dprod_ff <= s2_dprod_in;
         s2_sprod_ff <= s2_sprod_in;
         s2_alpha_ff <= s1_alpha_ff;
      end
   end

   // Stage 3: add and divide by 255
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         s3_rgb_in[i] = div255({1'b0, s2_dprod_ff[i]} + {1'b0, s2_sprod_ff[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv) begin
         s3_rgb_ff   <= s3_rgb_in;
         s3_alpha_ff <= s2_alpha_ff;
      end
   end

   assign rsp_valid     = s3_valid_ff;
   assign rsp_out_red   = s3_rgb_ff[0];
   assign rsp_out_green = s3_rgb_ff[1];
   assign rsp_out_blue  = s3_rgb_ff[2];
   assign rsp_out_alpha = s3_alpha_ff;

   // An accepted beat always lands in stage 1.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted beat missing from stage 1");

   // A full stage stalled by its successor keeps its beat.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_open |=> s2_valid_ff && $stable(s2_dprod_ff) && $stable(s2_sprod_ff))
      else $error("stage 2 beat lost under stall");

   // Replace mode weight is the global alpha.
   a_replace_weight: assert property (@(posedge clock) disable iff (reset)
      s1_adv && blend_mode_ff == MODE_GLOBAL && !csr_wr_en |=>
         s1_weight_ff == global_alpha_ff)
      else $error("replace mode weight mismatch");

   // Add mode never weights below the source alpha.
   a_add_weight: assert property (@(posedge clock) disable iff (reset)
      s1_adv && blend_mode_ff == MODE_ADD_GLOBAL |=>
         s1_weight_ff >= $past(req_src_alpha))
      else $error("add mode weight below source alpha");

endmodule

`default_nettype wire
